@@ rtl/exposure_statistics_macros.svh @@
// Assertion macros for the exposure statistics block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef EXPOSURE_STATISTICS_MACROS_SVH
`define EXPOSURE_STATISTICS_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define EXPST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("exposure_statistics: check failed");
// Next-cycle implication, disabled while in reset.
`define EXPST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("exposure_statistics: check failed");
`else
`define EXPST_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define EXPST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/expst_pkg.sv @@
// Shared constants, codes and types for the exposure statistics block.
// No dependencies; used by every other file in rtl but the macros header.
package expst_pkg;

  localparam int CHAN_W     = 8;
  localparam int LUMA_W     = 8;
  localparam int CNT_W      = 25;
  localparam int SUM_W      = 33;
  localparam int PCT_W      = 14;
  localparam int AVG_W      = 15;
  localparam int QUOT_W     = 15;
  localparam int DIVD_W     = 40;
  localparam int ITER_W     = 4;
  localparam int FMT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int LUMA_SHIFT = 16;
  localparam int MIX_W      = 24;

  localparam logic [CNT_W-1:0] MAX_PIXELS = 25'd16777216;

  // BT.601 weights in 16-bit fixed point
  localparam logic [15:0] COEF_R = 16'd19595;
  localparam logic [15:0] COEF_G = 16'd38470;
  localparam logic [15:0] COEF_B = 16'd7471;

  localparam logic [13:0] PCT_SCALE = 14'd10000;
  localparam logic [6:0]  AVG_SCALE = 7'd100;

  localparam logic [LUMA_W-1:0] SHADOW_RESET    = 8'd25;
  localparam logic [LUMA_W-1:0] HIGHLIGHT_RESET = 8'd230;

  // Pixel format codes; code three falls back to RGB order
  localparam logic [FMT_W-1:0] FMT_GRAY = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BGR  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_BELOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT_ABOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SAVE,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_SHADOW,
    SEL_HIGHLIGHT,
    SEL_LUMA
  } stat_sel_t;

  typedef struct packed {
    logic      load;
    logic      step;
    logic      save;
    logic      publish;
    stat_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic last_acc;
  } dp_status_t;

endpackage

@@ rtl/expst_if.sv @@
// Valid/ready channel interfaces for pixel input and statistics result.
// Depends on expst_pkg for field widths.
interface expst_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [expst_pkg::CHAN_W-1:0] chan_first;
  logic [expst_pkg::CHAN_W-1:0] chan_second;
  logic [expst_pkg::CHAN_W-1:0] chan_third;
  logic                        last_pixel;

  modport source (output valid, chan_first, chan_second, chan_third, last_pixel,
                  input ready);
  modport sink (input valid, chan_first, chan_second, chan_third, last_pixel,
                output ready);
endinterface

interface expst_result_if;
  logic                        valid;
  logic                        ready;
  logic [expst_pkg::PCT_W-1:0] shadow_pct_x100;
  logic [expst_pkg::PCT_W-1:0] highlight_pct_x100;
  logic [expst_pkg::AVG_W-1:0] avg_luma_x100;
  logic [expst_pkg::CNT_W-1:0] pixel_total;
  logic                        count_overflow;

  modport source (output valid, shadow_pct_x100, highlight_pct_x100, avg_luma_x100,
                  pixel_total, count_overflow, input ready);
  modport sink (input valid, shadow_pct_x100, highlight_pct_x100, avg_luma_x100,
                pixel_total, count_overflow, output ready);
endinterface

@@ rtl/expst_luma.sv @@
// Luma stage: selects channel order and forms BT.601 luma, one register deep.
// Gray format passes chan_first through. Depends on expst_pkg.
module expst_luma (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [expst_pkg::CHAN_W-1:0]  chan_first,
  input  logic [expst_pkg::CHAN_W-1:0]  chan_second,
  input  logic [expst_pkg::CHAN_W-1:0]  chan_third,
  input  logic                          last_pixel,
  input  logic [expst_pkg::FMT_W-1:0]   pixel_format,
  output logic                          luma_valid,
  output logic [expst_pkg::LUMA_W-1:0]  luma,
  output logic                          luma_last
);

  logic [expst_pkg::CHAN_W-1:0] red;
  logic [expst_pkg::CHAN_W-1:0] blue;
  logic [expst_pkg::MIX_W-1:0]  mix;
  logic [expst_pkg::LUMA_W-1:0] luma_next;

  always_comb begin
    if (pixel_format == expst_pkg::FMT_BGR) begin
      red  = chan_third;
      blue = chan_first;
    end else begin
      red  = chan_first;
      blue = chan_third;
    end
    // weights sum to 65536, so the weighted sum stays below 2^24
    mix = expst_pkg::MIX_W'(red * expst_pkg::COEF_R)
        + expst_pkg::MIX_W'(chan_second * expst_pkg::COEF_G)
        + expst_pkg::MIX_W'(blue * expst_pkg::COEF_B);
    if (pixel_format == expst_pkg::FMT_GRAY) begin
      luma_next = chan_first;
    end else begin
      luma_next = mix[expst_pkg::MIX_W-1:expst_pkg::LUMA_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_valid <= 1'b0;
    end else begin
      luma_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      luma      <= luma_next;
      luma_last <= last_pixel;
    end
  end

endmodule

@@ rtl/expst_datapath.sv @@
// Accumulators, shared restoring divider and result payload registers.
// Depends on expst_pkg; driven by expst_ctrl through dp_cmd_t.
module expst_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          luma_valid,
  input  logic [expst_pkg::LUMA_W-1:0]  luma,
  input  logic                          luma_last,
  input  logic [expst_pkg::LUMA_W-1:0]  shadow_below,
  input  logic [expst_pkg::LUMA_W-1:0]  highlight_above,
  input  expst_pkg::dp_cmd_t            cmd,
  output expst_pkg::dp_status_t         status,
  output logic [expst_pkg::PCT_W-1:0]   shadow_pct_x100,
  output logic [expst_pkg::PCT_W-1:0]   highlight_pct_x100,
  output logic [expst_pkg::AVG_W-1:0]   avg_luma_x100,
  output logic [expst_pkg::CNT_W-1:0]   pixel_total,
  output logic                          count_overflow
);

  logic [expst_pkg::CNT_W-1:0]  shadow_count;
  logic [expst_pkg::CNT_W-1:0]  highlight_count;
  logic [expst_pkg::SUM_W-1:0]  luma_sum;
  logic [expst_pkg::CNT_W-1:0]  pixel_count;
  logic                         overflow_seen;

  logic [expst_pkg::DIVD_W-1:0] operand;
  logic [expst_pkg::DIVD_W-1:0] rem;
  logic [expst_pkg::DIVD_W-1:0] dsh;
  logic [expst_pkg::QUOT_W-1:0] quot;
  logic                         fits;

  logic [expst_pkg::PCT_W-1:0]  shadow_q;
  logic [expst_pkg::PCT_W-1:0]  highlight_q;
  logic [expst_pkg::AVG_W-1:0]  avg_q;

  assign status.last_acc = luma_valid & luma_last;

  always_ff @(posedge clk) begin
    if (rst || cmd.publish) begin
      shadow_count    <= '0;
      highlight_count <= '0;
      luma_sum        <= '0;
      pixel_count     <= '0;
      overflow_seen   <= 1'b0;
    end else if (luma_valid) begin
      if (pixel_count == expst_pkg::MAX_PIXELS) begin
        // saturated: drop the pixel
        overflow_seen <= 1'b1;
      end else begin
        pixel_count <= pixel_count + 1'b1;
        luma_sum    <= luma_sum + expst_pkg::SUM_W'(luma);
        if (luma < shadow_below) begin
          shadow_count <= shadow_count + 1'b1;
        end else if (luma > highlight_above) begin
          highlight_count <= highlight_count + 1'b1;
        end
      end
    end
  end

  // scaled dividend for the selected statistic
  always_comb begin
    unique case (cmd.sel)
      expst_pkg::SEL_SHADOW: begin
        operand = expst_pkg::DIVD_W'(shadow_count) * expst_pkg::DIVD_W'(expst_pkg::PCT_SCALE);
      end
      expst_pkg::SEL_HIGHLIGHT: begin
        operand = expst_pkg::DIVD_W'(highlight_count)
                * expst_pkg::DIVD_W'(expst_pkg::PCT_SCALE);
      end
      expst_pkg::SEL_LUMA: begin
        operand = expst_pkg::DIVD_W'(luma_sum) * expst_pkg::DIVD_W'(expst_pkg::AVG_SCALE);
      end
      default: begin
        operand = '0;
      end
    endcase
  end

  assign fits = (rem >= dsh);

  // restoring division, one quotient bit per step, MSB first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= operand;
      dsh  <= expst_pkg::DIVD_W'(pixel_count) << (expst_pkg::QUOT_W - 1);
      quot <= '0;
    end else if (cmd.step) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[expst_pkg::QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save) begin
      unique case (cmd.sel)
        expst_pkg::SEL_SHADOW:    shadow_q    <= quot[expst_pkg::PCT_W-1:0];
        expst_pkg::SEL_HIGHLIGHT: highlight_q <= quot[expst_pkg::PCT_W-1:0];
        expst_pkg::SEL_LUMA:      avg_q       <= quot[expst_pkg::AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      shadow_pct_x100    <= shadow_q;
      highlight_pct_x100 <= highlight_q;
      avg_luma_x100      <= avg_q;
      pixel_total        <= pixel_count;
      count_overflow     <= overflow_seen;
    end
  end

endmodule

@@ rtl/expst_ctrl.sv @@
// Sequencer for the end-of-region divisions and the result handshake.
// Depends on expst_pkg and exposure_statistics_macros.svh.
`include "exposure_statistics_macros.svh"

module expst_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  expst_pkg::dp_status_t  status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   in_ready,
  output expst_pkg::dp_cmd_t     cmd
);

  expst_pkg::ctrl_state_t        state;
  expst_pkg::ctrl_state_t        state_next;
  expst_pkg::stat_sel_t          sel;
  expst_pkg::stat_sel_t          sel_next;
  logic [expst_pkg::ITER_W-1:0]  cnt;
  logic [expst_pkg::ITER_W-1:0]  cnt_next;
  logic                          out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      expst_pkg::ST_IDLE: begin
        if (status.last_acc) state_next = expst_pkg::ST_LOAD;
      end
      expst_pkg::ST_LOAD: begin
        state_next = expst_pkg::ST_DIV;
      end
      expst_pkg::ST_DIV: begin
        if (cnt == '0) state_next = expst_pkg::ST_SAVE;
      end
      expst_pkg::ST_SAVE: begin
        if (sel == expst_pkg::SEL_LUMA) begin
          state_next = expst_pkg::ST_FINISH;
        end else begin
          state_next = expst_pkg::ST_LOAD;
        end
      end
      expst_pkg::ST_FINISH: begin
        if (out_free) state_next = expst_pkg::ST_IDLE;
      end
      default: begin
        state_next = expst_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sel_next = sel;
    cnt_next = cnt;
    unique case (state)
      expst_pkg::ST_IDLE: begin
        sel_next = expst_pkg::SEL_SHADOW;
      end
      expst_pkg::ST_LOAD: begin
        cnt_next = expst_pkg::ITER_W'(expst_pkg::QUOT_W - 1);
      end
      expst_pkg::ST_DIV: begin
        cnt_next = cnt - 1'b1;
      end
      expst_pkg::ST_SAVE: begin
        unique case (sel)
          expst_pkg::SEL_SHADOW:    sel_next = expst_pkg::SEL_HIGHLIGHT;
          expst_pkg::SEL_HIGHLIGHT: sel_next = expst_pkg::SEL_LUMA;
          default:                  sel_next = expst_pkg::SEL_SHADOW;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.sel     = sel;
    cmd.load    = (state == expst_pkg::ST_LOAD);
    cmd.step    = (state == expst_pkg::ST_DIV);
    cmd.save    = (state == expst_pkg::ST_SAVE);
    cmd.publish = (state == expst_pkg::ST_FINISH) && out_free;
    in_ready    = (state == expst_pkg::ST_IDLE) && !status.last_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= expst_pkg::ST_IDLE;
      sel       <= expst_pkg::SEL_SHADOW;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      cnt   <= cnt_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `EXPST_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == expst_pkg::ST_IDLE)
  `EXPST_ASSERT_IMPL(a_publish_free, clk, rst, cmd.publish, !out_valid || out_ready)
  `EXPST_ASSERT_NEXT(a_div_done, clk, rst, (state == expst_pkg::ST_DIV) && (cnt == '0), state == expst_pkg::ST_SAVE)
  `EXPST_ASSERT_NEXT(a_idle_hold, clk, rst, (state == expst_pkg::ST_IDLE) && !status.last_acc, state == expst_pkg::ST_IDLE)

endmodule

@@ rtl/exposure_statistics.sv @@
// Top level of the exposure statistics block: config registers and wiring.
// Depends on expst_pkg, expst_if, expst_luma, expst_datapath, expst_ctrl.
//
// Streams the pixels of one image region (one per transfer) and, on the
// transfer marked last_pixel, returns one result: shadow and highlight shares
// and mean luma in hundredths (truncated), the pixel count, and an overflow
// flag once more than MAX_PIXELS pixels arrived (extra pixels are dropped and
// the counts saturate). Within a region a pixel is taken every cycle. After
// the last pixel the input stalls while one shared restoring divider
// produces the three quotients, one bit per cycle (three passes of load +
// 15 steps + save, between the luma register and the publish); the publish
// waits further if the previous result has not been taken. The result sits
// in an output register, so a pending result does not stop accumulation of
// the next region. A pixel_format write takes effect on the next pixel; a
// shadow_below or highlight_above write applies already to a pixel taken
// in the same cycle. Writes to an index past the list are ignored.
module exposure_statistics (
  input  logic                              clk,
  input  logic                              rst,
  expst_pixel_if.sink                       pixel,
  expst_result_if.source                    result,
  input  logic                              cfg_we,
  input  logic [expst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [expst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [expst_pkg::FMT_W-1:0]  pixel_format;
  logic [expst_pkg::LUMA_W-1:0] shadow_below;
  logic [expst_pkg::LUMA_W-1:0] highlight_above;

  logic                         pix_accept;
  logic                         luma_valid;
  logic [expst_pkg::LUMA_W-1:0] luma;
  logic                         luma_last;

  expst_pkg::dp_cmd_t           cmd;
  expst_pkg::dp_status_t        status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format    <= expst_pkg::FMT_GRAY;
      shadow_below    <= expst_pkg::SHADOW_RESET;
      highlight_above <= expst_pkg::HIGHLIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        expst_pkg::REG_PIXEL_FORMAT:    pixel_format    <= cfg_data[expst_pkg::FMT_W-1:0];
        expst_pkg::REG_SHADOW_BELOW:    shadow_below    <= cfg_data;
        expst_pkg::REG_HIGHLIGHT_ABOVE: highlight_above <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign pix_accept = pixel.valid && pixel.ready;

  // stage 1: luma per pixel
  expst_luma u_luma (
    .clk          (clk),
    .rst          (rst),
    .accept       (pix_accept),
    .chan_first   (pixel.chan_first),
    .chan_second  (pixel.chan_second),
    .chan_third   (pixel.chan_third),
    .last_pixel   (pixel.last_pixel),
    .pixel_format (pixel_format),
    .luma_valid   (luma_valid),
    .luma         (luma),
    .luma_last    (luma_last)
  );

  // stage 2: accumulate, then divide at end of region
  expst_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .luma_valid         (luma_valid),
    .luma               (luma),
    .luma_last          (luma_last),
    .shadow_below       (shadow_below),
    .highlight_above    (highlight_above),
    .cmd                (cmd),
    .status             (status),
    .shadow_pct_x100    (result.shadow_pct_x100),
    .highlight_pct_x100 (result.highlight_pct_x100),
    .avg_luma_x100      (result.avg_luma_x100),
    .pixel_total        (result.pixel_total),
    .count_overflow     (result.count_overflow)
  );

  // sequencer: gates input from the last pixel until publish, owns result valid
  expst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .in_ready  (pixel.ready),
    .cmd       (cmd)
  );

endmodule
